>>> src/bdqs_pkg.sv
// Shared types and constants for the bounded deque with search.
// Used by the controller, the datapath and the top level; depends on nothing.

package bdqs_pkg;

   localparam int OP_BITS     = 3;
   localparam int VALUE_BITS  = 64;
   localparam int CNT_BITS    = 7;
   localparam int STATUS_BITS = 2;

   // Command codes.
   localparam logic [OP_BITS-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_BITS-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_BITS-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_BITS-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_BITS-1:0] OP_CLEAR      = 3'd4;
   localparam logic [OP_BITS-1:0] OP_FIND       = 3'd5;

   // Result status codes.
   localparam logic [STATUS_BITS-1:0] ST_SUCCESS   = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FAILURE   = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FOUND     = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd3;

   // Controller to datapath.
   typedef struct packed {
      logic exec;   // item accepted: apply the command to the pointers and store
      logic fetch;  // read the entry under the search index
      logic check;  // compare the fetched entry with the key
      logic load;   // move the finished result into the output register
   } ctrl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic search_start;  // incoming item is a find on a non-empty queue
      logic match;         // fetched entry equals the key
      logic last_idx;      // search index points at the back entry
      logic rsp_free;      // output register can take a result this cycle
   } dp_status_type;

endpackage

>>> src/bdqs_ram.sv
// Generic simple dual-read RAM: one write port, two registered read ports.
// Stand-alone; no package dependency.

module bdqs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> src/bdqs_ctrl.sv
// Sequencer for the bounded deque: accepts an item, steps a find through the
// held entries, reads front and back, and hands the result over. Uses bdqs_pkg.

module bdqs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  bdqs_pkg::dp_status_type stat,
   output bdqs_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_CHECK,
      S_READ,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      stall_ff;
   logic      stall_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !stall_ff) begin
               cmd.exec = 1'b1;
               state_in = stat.search_start ? S_FETCH : S_READ;
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = (stat.match || stat.last_idx) ? S_READ : S_FETCH;
         end
         S_READ: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (stat.rsp_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      stall_in = (state_in != S_IDLE);
   end

   // Stall is held high through reset so that nothing is taken before the
   // first idle cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         stall_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         stall_ff <= stall_in;
      end
   end

   assign req_stall = stall_ff;

endmodule

>>> src/bdqs_dpath.sv
// Datapath of the bounded deque: capacity register, front pointer and count,
// entry store, search index and the output register. Uses bdqs_pkg and bdqs_ram.

module bdqs_dpath #(
   parameter int DEPTH      = 64,
   parameter int ENTRY_BITS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [bdqs_pkg::CNT_BITS-1:0]       csr_write_data,
   input  logic [bdqs_pkg::OP_BITS-1:0]        req_operation,
   input  logic [bdqs_pkg::VALUE_BITS-1:0]     req_entry_value,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [bdqs_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic [bdqs_pkg::CNT_BITS-1:0]       rsp_entry_count,
   output logic                                rsp_is_empty,
   output logic [bdqs_pkg::VALUE_BITS-1:0]     rsp_front_value,
   output logic [bdqs_pkg::VALUE_BITS-1:0]     rsp_back_value,
   output logic                                rsp_front_back_valid,
   input  bdqs_pkg::ctrl_cmd_type               cmd,
   output bdqs_pkg::dp_status_type              stat
);

   localparam int POS_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS  = bdqs_pkg::CNT_BITS;
   localparam int CNTX_BITS = CNT_BITS + 1;
   localparam int SUM_BITS  = ((POS_BITS > CNT_BITS) ? POS_BITS : CNT_BITS) + 1;

   logic [CNT_BITS-1:0]              capacity_ff;
   logic [POS_BITS-1:0]              first_ff;
   logic [POS_BITS-1:0]              first_in;
   logic [CNT_BITS-1:0]              count_ff;
   logic [CNT_BITS-1:0]              count_in;
   logic [CNT_BITS-1:0]              idx_ff;
   logic [ENTRY_BITS-1:0]            key_ff;
   logic [bdqs_pkg::STATUS_BITS-1:0] status_ff;
   logic [bdqs_pkg::STATUS_BITS-1:0] status_in;

   logic [bdqs_pkg::STATUS_BITS-1:0] rsp_status_ff;
   logic [CNT_BITS-1:0]              rsp_count_ff;
   logic                             rsp_empty_ff;
   logic [bdqs_pkg::VALUE_BITS-1:0]  rsp_front_ff;
   logic [bdqs_pkg::VALUE_BITS-1:0]  rsp_back_ff;
   logic                             rsp_fbv_ff;
   logic                             rsp_valid_ff;

   logic                  evict;
   logic                  is_push;
   logic                  wr_en;
   logic [POS_BITS-1:0]   wr_addr;
   logic [ENTRY_BITS-1:0] new_value;
   logic [POS_BITS-1:0]   first_inc;
   logic [POS_BITS-1:0]   first_dec;
   logic [POS_BITS-1:0]   tail_pos;
   logic [POS_BITS-1:0]   back_pos;
   logic [POS_BITS-1:0]   search_pos;
   logic [POS_BITS-1:0]   rd_addr_a;
   logic [ENTRY_BITS-1:0] rd_data_a;
   logic [ENTRY_BITS-1:0] rd_data_b;
   logic [CNT_BITS-1:0]   count_m1;
   logic                  count_zero;

   // The front pointer is below DEPTH and the offset at most DEPTH, so one conditional subtract wraps the sum.
   function automatic logic [POS_BITS-1:0] wrap_pos(input logic [SUM_BITS-1:0] sum);
      logic [SUM_BITS-1:0] adj;
      adj = (sum >= SUM_BITS'(DEPTH)) ? sum - SUM_BITS'(DEPTH) : sum;
      return adj[POS_BITS-1:0];
   endfunction

   assign count_zero = (count_ff == '0);
   assign count_m1   = count_ff - CNT_BITS'(1);
   assign new_value  = req_entry_value[ENTRY_BITS-1:0];

   assign first_inc  = wrap_pos(SUM_BITS'(first_ff) + SUM_BITS'(1));
   assign first_dec  = (first_ff == '0) ? POS_BITS'(DEPTH - 1) : first_ff - POS_BITS'(1);
   assign tail_pos   = wrap_pos(SUM_BITS'(first_ff) + SUM_BITS'(count_ff));
   assign back_pos   = wrap_pos(SUM_BITS'(first_ff) + SUM_BITS'(count_m1));
   assign search_pos = wrap_pos(SUM_BITS'(first_ff) + SUM_BITS'(idx_ff));

   // A push evicts when it would exceed the capacity or the store itself.
   assign evict = (CNTX_BITS'(count_ff) + CNTX_BITS'(1) > CNTX_BITS'(capacity_ff))
                  || (32'(count_ff) >= 32'(DEPTH));
   assign is_push = (req_operation == bdqs_pkg::OP_PUSH_FRONT)
                    || (req_operation == bdqs_pkg::OP_PUSH_BACK);

   always_comb begin
      first_in  = first_ff;
      count_in  = count_ff;
      status_in = bdqs_pkg::ST_SUCCESS;
      wr_addr   = tail_pos;
      unique case (req_operation)
         bdqs_pkg::OP_PUSH_FRONT: begin
            // Dropping the back needs no pointer change; the front pointer steps back as for any push.
            wr_addr = first_dec;
            if (!(evict && count_zero)) begin
               first_in = first_dec;
               count_in = evict ? count_ff : count_ff + CNT_BITS'(1);
            end
         end
         bdqs_pkg::OP_PUSH_BACK: begin
            // With an eviction the front pointer steps past the dropped front entry.
            wr_addr = tail_pos;
            if (!(evict && count_zero)) begin
               first_in = evict ? first_inc : first_ff;
               count_in = evict ? count_ff : count_ff + CNT_BITS'(1);
            end
         end
         bdqs_pkg::OP_POP_FRONT: begin
            if (count_zero) begin
               status_in = bdqs_pkg::ST_FAILURE;
            end else begin
               first_in = first_inc;
               count_in = count_m1;
            end
         end
         bdqs_pkg::OP_POP_BACK: begin
            if (count_zero) begin
               status_in = bdqs_pkg::ST_FAILURE;
            end else begin
               count_in = count_m1;
            end
         end
         bdqs_pkg::OP_CLEAR: begin
            count_in = '0;
         end
         bdqs_pkg::OP_FIND: begin
            status_in = bdqs_pkg::ST_NOT_FOUND;
         end
         default: begin
            status_in = bdqs_pkg::ST_SUCCESS;
         end
      endcase
   end

   assign wr_en     = cmd.exec && is_push && !(evict && count_zero);
   assign rd_addr_a = cmd.fetch ? search_pos : first_ff;

   bdqs_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (new_value),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (back_pos),
      .rd_data_b (rd_data_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= '0;
         first_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
         if (cmd.exec) begin
            first_ff <= first_in;
            count_ff <= count_in;
         end
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_in;
         key_ff    <= new_value;
         idx_ff    <= '0;
      end else if (cmd.check) begin
         if (stat.match) begin
            status_ff <= bdqs_pkg::ST_FOUND;
         end else begin
            idx_ff <= idx_ff + CNT_BITS'(1);
         end
      end
      if (cmd.load) begin
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= count_ff;
         rsp_empty_ff  <= count_zero;
         rsp_fbv_ff    <= !count_zero;
         rsp_front_ff  <= count_zero ? '0 : bdqs_pkg::VALUE_BITS'(rd_data_a);
         rsp_back_ff   <= count_zero ? '0 : bdqs_pkg::VALUE_BITS'(rd_data_b);
      end
   end

   assign stat.search_start = (req_operation == bdqs_pkg::OP_FIND) && !count_zero;
   assign stat.match        = (rd_data_a == key_ff);
   assign stat.last_idx     = (idx_ff == count_m1);
   assign stat.rsp_free     = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_entry_count      = rsp_count_ff;
   assign rsp_is_empty         = rsp_empty_ff;
   assign rsp_front_value      = rsp_front_ff;
   assign rsp_back_value       = rsp_back_ff;
   assign rsp_front_back_valid = rsp_fbv_ff;

endmodule

>>> src/bounded_deque_with_search.sv
// Bounded double-ended queue of ENTRY_BITS-wide words with a capacity
// register and a search command. An accepted item passes S_READ and
// S_FINISH; a find first alternates S_FETCH and S_CHECK for each entry
// compared up to a match or the back entry, because the entries come out
// of one RAM read port with a registered read and are compared one at a
// time. No new item is taken until the result is in the output register.
// A result waits in an output register while the next item is accepted.
// The entry store has no reset; only written slots are ever read.

module bounded_deque_with_search #(
   parameter int DEPTH      = 64,
   parameter int ENTRY_BITS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [bdqs_pkg::CNT_BITS-1:0]       csr_write_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [bdqs_pkg::OP_BITS-1:0]        req_operation,
   input  logic [bdqs_pkg::VALUE_BITS-1:0]     req_entry_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bdqs_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic [bdqs_pkg::CNT_BITS-1:0]       rsp_entry_count,
   output logic                                rsp_is_empty,
   output logic [bdqs_pkg::VALUE_BITS-1:0]     rsp_front_value,
   output logic [bdqs_pkg::VALUE_BITS-1:0]     rsp_back_value,
   output logic                                rsp_front_back_valid
);

   bdqs_pkg::ctrl_cmd_type  cmd;
   bdqs_pkg::dp_status_type stat;

   bdqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   bdqs_dpath #(
      .DEPTH      (DEPTH),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_operation        (req_operation),
      .req_entry_value      (req_entry_value),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status),
      .rsp_entry_count      (rsp_entry_count),
      .rsp_is_empty         (rsp_is_empty),
      .rsp_front_value      (rsp_front_value),
      .rsp_back_value       (rsp_back_value),
      .rsp_front_back_valid (rsp_front_back_valid),
      .cmd                  (cmd),
      .stat                 (stat)
   );

endmodule

>>> src/bdqs_checker.sv
// Port-level checks for bounded_deque_with_search and the bind that attaches them.
// Uses bdqs_pkg for the status codes and field widths.

module bdqs_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [bdqs_pkg::STATUS_BITS-1:0]    rsp_status,
   input logic [bdqs_pkg::CNT_BITS-1:0]       rsp_entry_count,
   input logic                                rsp_is_empty,
   input logic [bdqs_pkg::VALUE_BITS-1:0]     rsp_front_value,
   input logic [bdqs_pkg::VALUE_BITS-1:0]     rsp_back_value,
   input logic                                rsp_front_back_valid
);

   // A pop can only fail on an empty queue, which it leaves empty.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == bdqs_pkg::ST_FAILURE) |-> rsp_is_empty)
      else $error("failure status on a non-empty queue");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_entry_count == '0))
                    && (rsp_front_back_valid == !rsp_is_empty))
      else $error("empty flag, count and front/back valid disagree");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_front_back_valid |-> (rsp_front_value == '0)
                                             && (rsp_back_value == '0))
      else $error("front or back value not zero on an empty queue");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
                                 && $stable(rsp_entry_count)
                                 && $stable(rsp_front_value)
                                 && $stable(rsp_back_value))
      else $error("stalled result item changed");

endmodule

bind bounded_deque_with_search bdqs_checker u_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_status           (rsp_status),
   .rsp_entry_count      (rsp_entry_count),
   .rsp_is_empty         (rsp_is_empty),
   .rsp_front_value      (rsp_front_value),
   .rsp_back_value       (rsp_back_value),
   .rsp_front_back_valid (rsp_front_back_valid)
);

>>> tb/tb.sv
// Self-checking testbench for bounded_deque_with_search: directed and random
// command streams with random valid and stall gaps, checked against a predictor.
// Depends on bdqs_pkg and the bounded_deque_with_search top level.

module tb;

   localparam logic [bdqs_pkg::OP_BITS-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [bdqs_pkg::OP_BITS-1:0] OP_SPARE_7 = 3'd7;
   localparam int SLOTS = 64;
   localparam int IDLE_LIMIT = 3000;
   localparam int PRINT_LIMIT = 100;

   typedef struct packed {
      logic [bdqs_pkg::STATUS_BITS-1:0] status;
      logic [bdqs_pkg::CNT_BITS-1:0]    count;
      logic                             empty;
      logic [bdqs_pkg::VALUE_BITS-1:0]  front;
      logic [bdqs_pkg::VALUE_BITS-1:0]  back;
      logic                             fb_valid;
   } deque_result_type;

   class deque_scoreboard;
      logic [bdqs_pkg::VALUE_BITS-1:0] words [SLOTS];
      bit [5:0] head_slot;
      bit [6:0] fill;
      bit [6:0] cap_reg;
      deque_result_type expected_responses[$];
      int errors;
      int n_checked;

      function new();
         head_slot = 0;
         fill = 0;
         cap_reg = 0;
         errors = 0;
         n_checked = 0;
      endfunction

      function void load_capacity(bit [6:0] c);
         cap_reg = c;
      endfunction

      function int pending();
         return expected_responses.size();
      endfunction

      // Applies one command to the local copy of the deque and queues the
      // response that the block must return for it.
      function void take_command(logic [bdqs_pkg::OP_BITS-1:0] op,
                                 logic [bdqs_pkg::VALUE_BITS-1:0] v);
         deque_result_type r;
         int lim;
         bit [5:0] tail_slot;
         r = '0;
         r.status = bdqs_pkg::ST_SUCCESS;
         lim = (cap_reg > SLOTS) ? SLOTS : cap_reg;
         case (op)
            bdqs_pkg::OP_PUSH_FRONT, bdqs_pkg::OP_PUSH_BACK: begin
               // With no room and nothing held, the new word is dropped at once.
               if (!(fill + 1 > lim && fill == 0)) begin
                  if (fill + 1 > lim) begin
                     if (op == bdqs_pkg::OP_PUSH_BACK) head_slot++;
                     fill--;
                  end
                  if (op == bdqs_pkg::OP_PUSH_FRONT) begin
                     head_slot--;
                     words[head_slot] = v;
                  end else begin
                     tail_slot = head_slot + fill[5:0];
                     words[tail_slot] = v;
                  end
                  fill++;
               end
            end
            bdqs_pkg::OP_POP_FRONT: begin
               if (fill == 0) r.status = bdqs_pkg::ST_FAILURE;
               else begin
                  head_slot++;
                  fill--;
               end
            end
            bdqs_pkg::OP_POP_BACK: begin
               if (fill == 0) r.status = bdqs_pkg::ST_FAILURE;
               else fill--;
            end
            bdqs_pkg::OP_CLEAR: begin
               fill = 0;
            end
            bdqs_pkg::OP_FIND: begin
               r.status = bdqs_pkg::ST_NOT_FOUND;
               for (int i = 0; i < fill; i++) begin
                  tail_slot = head_slot + 6'(i);
                  if (words[tail_slot] == v) r.status = bdqs_pkg::ST_FOUND;
               end
            end
            default: begin
            end
         endcase
         r.count = fill;
         r.empty = (fill == 0);
         if (fill != 0) begin
            tail_slot = head_slot + 6'(fill - 1);
            r.front = words[head_slot];
            r.back = words[tail_slot];
            r.fb_valid = 1'b1;
         end
         expected_responses = {expected_responses, r};
      endfunction

      task report(string what);
         if (errors < PRINT_LIMIT) $display("mismatch at %0t: %s", $time, what);
         errors++;
      endtask

      task check_response(deque_result_type got);
         deque_result_type want;
         if (expected_responses.size() == 0) begin
            report($sformatf("response with no command outstanding, status %0d count %0d",
                             got.status, got.count));
            return;
         end
         want = expected_responses[0];
         expected_responses.delete(0);
         n_checked++;
         if (got.status !== want.status)
            report($sformatf("response %0d status %0d, expected %0d",
                             n_checked, got.status, want.status));
         if (got.count !== want.count)
            report($sformatf("response %0d count %0d, expected %0d",
                             n_checked, got.count, want.count));
         if (got.empty !== want.empty)
            report($sformatf("response %0d empty %b, expected %b",
                             n_checked, got.empty, want.empty));
         if (got.front !== want.front)
            report($sformatf("response %0d front %h, expected %h",
                             n_checked, got.front, want.front));
         if (got.back !== want.back)
            report($sformatf("response %0d back %h, expected %h",
                             n_checked, got.back, want.back));
         if (got.fb_valid !== want.fb_valid)
            report($sformatf("response %0d front_back_valid %b, expected %b",
                             n_checked, got.fb_valid, want.fb_valid));
      endtask
   endclass

   logic                             clock;
   logic                             reset;
   logic                             csr_write_enable;
   logic [bdqs_pkg::CNT_BITS-1:0]    csr_write_data;
   logic                             req_valid;
   logic                             req_stall;
   logic [bdqs_pkg::OP_BITS-1:0]     req_operation;
   logic [bdqs_pkg::VALUE_BITS-1:0]  req_entry_value;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic [bdqs_pkg::STATUS_BITS-1:0] rsp_status;
   logic [bdqs_pkg::CNT_BITS-1:0]    rsp_entry_count;
   logic                             rsp_is_empty;
   logic [bdqs_pkg::VALUE_BITS-1:0]  rsp_front_value;
   logic [bdqs_pkg::VALUE_BITS-1:0]  rsp_back_value;
   logic                             rsp_front_back_valid;

   deque_scoreboard sb = new();
   bit calm = 1'b0;
   int idle_cycles = 0;
   logic [bdqs_pkg::VALUE_BITS-1:0] value_pool [8] = '{
      64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 64'h8000_0000_0000_0000,
      64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
      64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210
   };

   bounded_deque_with_search u_top (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_operation        (req_operation),
      .req_entry_value      (req_entry_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_entry_count      (rsp_entry_count),
      .rsp_is_empty         (rsp_is_empty),
      .rsp_front_value      (rsp_front_value),
      .rsp_back_value       (rsp_back_value),
      .rsp_front_back_valid (rsp_front_back_valid)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      deque_result_type got;
      if (!reset) begin
         if (csr_write_enable) sb.load_capacity(csr_write_data);
         if (req_valid && !req_stall) sb.take_command(req_operation, req_entry_value);
         if (rsp_valid && !rsp_stall) begin
            got.status = rsp_status;
            got.count = rsp_entry_count;
            got.empty = rsp_is_empty;
            got.front = rsp_front_value;
            got.back = rsp_back_value;
            got.fb_valid = rsp_front_back_valid;
            sb.check_response(got);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("** bounded_deque_with_search: FAILED **");
         $finish;
      end
   end

   // The receiver stalls for a random number of cycles before each item.
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         n = calm ? 0 : $urandom_range(0, 6);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
      end
   end

   function automatic logic [bdqs_pkg::VALUE_BITS-1:0] pick_value();
      if ($urandom_range(0, 1)) return value_pool[$urandom_range(0, 7)];
      return {$urandom(), $urandom()};
   endfunction

   // Returns right after the edge at which the item was accepted; valid is
   // left high so that a back-to-back item keeps it high.
   task automatic send_item(input logic [bdqs_pkg::OP_BITS-1:0] op,
                            input logic [bdqs_pkg::VALUE_BITS-1:0] val);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 6);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_entry_value <= val;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [bdqs_pkg::CNT_BITS-1:0] c);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data <= c;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_phase(input logic [bdqs_pkg::CNT_BITS-1:0] c, input int n,
                            input int push_pct, input bit quiet);
      int r;
      int s;
      write_capacity(c);
      calm = quiet;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         s = $urandom_range(0, 99);
         if (r == 0) drain_results();
         if (r < push_pct)
            send_item(s < 50 ? bdqs_pkg::OP_PUSH_FRONT : bdqs_pkg::OP_PUSH_BACK,
                      pick_value());
         else if (s < 28) send_item(bdqs_pkg::OP_POP_FRONT, pick_value());
         else if (s < 56) send_item(bdqs_pkg::OP_POP_BACK, pick_value());
         else if (s < 92) send_item(bdqs_pkg::OP_FIND, pick_value());
         else if (s < 96) send_item(bdqs_pkg::OP_CLEAR, pick_value());
         else if (s < 98) send_item(OP_SPARE_6, pick_value());
         else send_item(OP_SPARE_7, pick_value());
      end
      calm = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = bdqs_pkg::OP_CLEAR;
      req_entry_value = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Capacity is zero out of reset: pushes vanish, pops fail.
      send_item(bdqs_pkg::OP_PUSH_FRONT, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(bdqs_pkg::OP_PUSH_BACK, 64'h1);
      send_item(bdqs_pkg::OP_POP_FRONT, 64'h0);
      send_item(bdqs_pkg::OP_POP_BACK, 64'h0);
      send_item(bdqs_pkg::OP_FIND, 64'h0);
      send_item(OP_SPARE_6, 64'h0);
      send_item(OP_SPARE_7, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(bdqs_pkg::OP_CLEAR, 64'h0);

      write_capacity(7'd3);
      send_item(bdqs_pkg::OP_PUSH_BACK, 64'h0);
      send_item(bdqs_pkg::OP_PUSH_BACK, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(bdqs_pkg::OP_PUSH_FRONT, 64'h5555_5555_5555_5555);
      send_item(bdqs_pkg::OP_PUSH_BACK, 64'hAAAA_AAAA_AAAA_AAAA);
      send_item(bdqs_pkg::OP_PUSH_FRONT, 64'h8000_0000_0000_0000);
      send_item(bdqs_pkg::OP_FIND, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(bdqs_pkg::OP_FIND, 64'h1234);

      // Lowering the capacity under the count: each push evicts only one word.
      write_capacity(7'd1);
      send_item(bdqs_pkg::OP_PUSH_BACK, 64'h0123_4567_89AB_CDEF);
      send_item(bdqs_pkg::OP_FIND, 64'h0123_4567_89AB_CDEF);
      send_item(bdqs_pkg::OP_POP_FRONT, 64'h0);
      send_item(bdqs_pkg::OP_POP_BACK, 64'h0);
      send_item(bdqs_pkg::OP_CLEAR, 64'h0);
      send_item(bdqs_pkg::OP_POP_BACK, 64'h0);

      run_phase(7'd127, 130, 80, 1'b0);
      run_phase(7'd64, 100, 55, 1'b0);
      run_phase(7'd5, 100, 50, 1'b0);
      run_phase(7'd0, 60, 50, 1'b0);
      run_phase(7'd1, 80, 50, 1'b0);
      run_phase(7'd2, 100, 50, 1'b1);
      run_phase(7'd16, 120, 60, 1'b0);
      run_phase(7'd65, 110, 75, 1'b0);
      run_phase(7'($urandom_range(0, 127)), 100, 60, 1'b0);
      run_phase(7'd3, 100, 50, 1'b0);

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("** bounded_deque_with_search: PASSED **");
      end else begin
         $display("** bounded_deque_with_search: FAILED **");
      end
      $finish;
   end
endmodule

>>> filelist.f
src/bdqs_pkg.sv
src/bdqs_ram.sv
src/bdqs_ctrl.sv
src/bdqs_dpath.sv
src/bounded_deque_with_search.sv
src/bdqs_checker.sv
tb/tb.sv
